// ----- sv/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int unsigned SBOX_DEPTH     = 256;
  localparam int unsigned SBOX_AW        = 8;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned KEY_LEN_W      = 5;
  localparam int unsigned WORD_BYTES     = CFG_DATA_W / BYTE_W;

  typedef enum logic [0:0] {
    CMD_RESTART = 1'b0,
    CMD_DATA    = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- sv/rc4_if.sv -----
// ----------------------------------------------------------------------------
// rc4_if
// Valid/ready channels of the RC4 core: input items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_e              cmd;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rc4_stream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 byte stream cipher: key schedule on restart, one keystream byte per
// data item, permutation held in a 256 x 8 synchronous RAM.
// ----------------------------------------------------------------------------
//   channel | dir | payload              | item
//   cfg_i   | in  | index, data          | register write, always ready
//   in_i    | in  | cmd, data_byte       | restart or data byte
//   out_o   | out | out_byte             | one per data item
//
// A data item steps from accept to next accept through read S[i], read
// S[j], write S[i] while reading S[S[i]+S[j]], write S[j] and load output.
// A restart runs 256 key schedule rounds (read S[n], read S[acc], write
// S[n], write S[acc]), bound by the single RAM write port (two writes per swap).
// Restart resets the table to identity by clearing all per-entry valid
// bits together; an invalid entry reads as its own address.
// A full output register stalls the last data step until the item is taken;
// the next input item may be accepted while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core import rc4_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rc4_cfg_if.sink  cfg_i,
  rc4_in_if.sink   in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_RD_J     = 8'b0000_0010,
    ST_SWAP     = 8'b0000_0100,
    ST_FIN      = 8'b0000_1000,
    ST_KS_RD_N  = 8'b0001_0000,
    ST_KS_RD_A  = 8'b0010_0000,
    ST_KS_WR_N  = 8'b0100_0000,
    ST_KS_WR_A  = 8'b1000_0000
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]    key_q [MAX_KEY_BYTES];
  logic [KEY_LEN_W-1:0] key_len_q;
  logic                 cfg_we;
  logic                 wr_low, wr_high, wr_len;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_comb begin
    wr_low  = 1'b0;
    wr_high = 1'b0;
    wr_len  = 1'b0;
    case (cfg_idx_e'(cfg_i.index))
      CFG_KEY_LOW:  wr_low  = cfg_we;
      CFG_KEY_HIGH: wr_high = cfg_we;
      CFG_KEY_LEN:  wr_len  = cfg_we;
      default: ;
    endcase
  end

  for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
    if (b < WORD_BYTES) begin : g_lo
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          key_q[b] <= '0;
        end else if (wr_low) begin
          key_q[b] <= cfg_i.data[BYTE_W*b +: BYTE_W];
        end
      end
    end else begin : g_hi
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          key_q[b] <= '0;
        end else if (wr_high) begin
          key_q[b] <= cfg_i.data[BYTE_W*(b-WORD_BYTES) +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KEY_LEN_W'(16);
    end else if (wr_len) begin
      key_len_q <= cfg_i.data[KEY_LEN_W-1:0];
    end
  end

  // zero acts as one, large values saturate
  logic [KEY_LEN_W-1:0] key_len_eff;
  always_comb begin
    if (key_len_q == '0) begin
      key_len_eff = KEY_LEN_W'(1);
    end else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_len_eff = key_len_q;
    end
  end

  // --------------------------------------------------------------------------
  // Permutation RAM, read-first, one read and one write port
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_q;
  logic                  mem_we;
  logic [SBOX_AW-1:0]    mem_waddr, mem_raddr, rd_addr_q;
  logic [BYTE_W-1:0]     mem_wdata, rd_data_q, rd_val;
  logic                  rd_vld_q, vld_clr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      rd_vld_q  <= vld_q[mem_raddr];
      rd_addr_q <= mem_raddr;
      if (vld_clr) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // entry never written since restart holds its own index
  assign rd_val = rd_vld_q ? rd_data_q : rd_addr_q;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [SBOX_AW-1:0]   i_q, i_d, j_q, j_d, t_q, t_d;
  logic [BYTE_W-1:0]    si_q, si_d, sj_q, sj_d, data_q, data_d;
  logic [SBOX_AW-1:0]   n_q, n_d, acc_q, acc_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d;
  logic [BYTE_W-1:0]    ks;
  logic                 in_acc, out_load, out_free;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    t_d       = t_q;
    si_d      = si_q;
    sj_d      = sj_q;
    data_d    = data_q;
    n_d       = n_q;
    acc_d     = acc_q;
    kidx_d    = kidx_q;
    mem_we    = 1'b0;
    mem_waddr = i_q;
    mem_wdata = rd_val;
    mem_raddr = i_q + 8'd1;
    vld_clr   = 1'b0;
    out_load  = 1'b0;
    // after the swap S[i] = sj and S[j] = si; the RAM may not show it yet
    if (t_q == i_q) begin
      ks = sj_q;
    end else if (t_q == j_q) begin
      ks = si_q;
    end else begin
      ks = rd_val;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == CMD_DATA) begin
            i_d     = i_q + 8'd1;
            data_d  = in_i.data_byte;
            state_d = ST_RD_J;
          end else begin
            vld_clr = 1'b1;
            i_d     = '0;
            j_d     = '0;
            n_d     = '0;
            acc_d   = '0;
            kidx_d  = '0;
            state_d = ST_KS_RD_N;
          end
        end
      end
      ST_RD_J: begin
        si_d      = rd_val;
        j_d       = j_q + rd_val;
        mem_raddr = j_q + rd_val;
        state_d   = ST_SWAP;
      end
      ST_SWAP: begin
        sj_d      = rd_val;
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rd_val;
        t_d       = si_q + rd_val;
        mem_raddr = si_q + rd_val;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // write repeats harmlessly while the output stalls
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        mem_raddr = t_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_KS_RD_N: begin
        mem_raddr = n_q;
        state_d   = ST_KS_RD_A;
      end
      ST_KS_RD_A: begin
        si_d      = rd_val;
        acc_d     = acc_q + rd_val + key_q[kidx_q];
        mem_raddr = acc_q + rd_val + key_q[kidx_q];
        if (KEY_LEN_W'(kidx_q) == key_len_eff - KEY_LEN_W'(1)) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KEY_IDX_W'(1);
        end
        state_d   = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = rd_val;
        state_d   = ST_KS_WR_A;
      end
      ST_KS_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = acc_q;
        mem_wdata = si_q;
        n_d       = n_q + 8'd1;
        if (n_q == SBOX_AW'(SBOX_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KS_RD_N;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      acc_q   <= '0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      acc_q   <= acc_d;
      kidx_q  <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= data_q ^ ks;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule

`default_nettype wire

// ----- sv/rc4_core_chk.sv -----
// ----------------------------------------------------------------------------
// rc4_core_chk
// Port-level checks of the RC4 core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_core_chk import rc4_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input cmd_e              in_cmd_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_byte_i
);

  logic       in_acc, data_acc, out_acc;
  logic [2:0] pend_q;

  assign in_acc   = in_valid_i && in_ready_i;
  assign data_acc = in_acc && (in_cmd_i == CMD_DATA);
  assign out_acc  = out_valid_i && out_ready_i;

  // data items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, data_acc} - {2'b00, out_acc};
    end
  end

  a_no_result_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result shown with no data item pending");

  a_at_most_two_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("more than two data items in flight");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item accepted back to back");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))
    else $error("stalled result changed");

endmodule

bind rc4_stream_cipher_core rc4_core_chk u_rc4_core_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte)
);

`default_nettype wire

// ----- tb/rc4_stream_cipher_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core_tb
// Self-checking bench for the RC4 core. A shadow copy of the permutation and
// indices predicts every output byte, across several keys and lengths, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core_tb;
  import rc4_pkg::*;

  localparam int unsigned KEY_BYTES_MAX  = 16;
  localparam int unsigned CLK_HALF_NS    = 2;
  localparam int unsigned RESTART_SETTLE = 1200;   // covers a full restart walk
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 190;
  localparam int unsigned RESTART_PCT    = 3;
  localparam int unsigned IDLE_HEAVY_PCT = 74;
  localparam int unsigned IDLE_BOTH_PCT  = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Shadow of the cipher state; predicts out_byte per accepted data item.
  class rc4_shadow;
    logic [BYTE_W-1:0]     sbox [SBOX_DEPTH];
    logic [BYTE_W-1:0]     idx_i, idx_j;
    logic [CFG_DATA_W-1:0] key_lo, key_hi;
    logic [KEY_LEN_W-1:0]  key_len;
    logic [BYTE_W-1:0]     expected_out [$];
    int unsigned           mismatches, bytes_checked, restarts_seen;

    function new();
      key_lo        = '0;
      key_hi        = '0;
      key_len       = 5'd16;
      mismatches    = 0;
      bytes_checked = 0;
      restarts_seen = 0;
      load_identity();
    endfunction

    function void load_identity();
      for (int n = 0; n < SBOX_DEPTH; n++) sbox[n] = n[BYTE_W-1:0];
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_KEY_LOW:  key_lo = val;
        CFG_KEY_HIGH: key_hi = val;
        CFG_KEY_LEN:  key_len = val[KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void rekey();
      int unsigned       len, k;
      logic [BYTE_W-1:0] acc, tmp, kb;
      len = 32'(key_len);
      if (len == 0) len = 1;
      if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
      load_identity();
      acc = '0;
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        k = n % len;
        kb = (k < WORD_BYTES) ? key_lo[8*k +: 8] : key_hi[8*(k-WORD_BYTES) +: 8];
        acc = acc + sbox[n] + kb;
        tmp = sbox[n];
        sbox[n] = sbox[acc];
        sbox[acc] = tmp;
      end
    endfunction

    function void accept_item(cmd_e c, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] tmp, ks;
      if (c == CMD_RESTART) begin
        rekey();
        restarts_seen++;
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        tmp = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = tmp;
        ks = sbox[sbox[idx_i] + sbox[idx_j]];
        expected_out.push_back(b ^ ks);
      end
    endfunction

    function void check_out_byte(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] exp_byte;
      if (expected_out.size() == 0) begin
        $error("out_byte: no item expected, actual %02h", got);
        mismatches++;
      end else begin
        exp_byte = expected_out.pop_front();
        bytes_checked++;
        if (got !== exp_byte) begin
          $error("out_byte mismatch: expected %02h, actual %02h", exp_byte, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned key_settings;
  rc4_shadow shadow = new();

  rc4_cfg_if cfg_ch ();
  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher_core #(
    .MAX_KEY_BYTES(KEY_BYTES_MAX)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Output side: check on handshake, then pick next ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        shadow.check_out_byte(out_ch.out_byte);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(cmd_e c, logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.data_byte <= b;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    shadow.accept_item(c, b);
  endtask

  task automatic send_data(logic [BYTE_W-1:0] b);
    send_item(CMD_DATA, b);
  endtask

  task automatic send_restart();
    send_item(CMD_RESTART, BYTE_W'($urandom_range(255)));
  endtask

  // Called in the step of an accept edge or later; lowers valid once and
  // returns at a later edge.
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.expected_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (cfg_ch.ready !== 1'b1) @(posedge clk_i);
    shadow.write_reg(idx, val);
  endtask

  // Block must be idle; a restart may still be walking the table, so settle.
  task automatic set_key(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                         logic [KEY_LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[KEY_LEN_W-1:0] = len;
    repeat (RESTART_SETTLE) @(posedge clk_i);
    cfg_write(CFG_KEY_LOW, lo);
    cfg_write(CFG_KEY_HIGH, hi);
    cfg_write(CFG_KEY_LEN, len_word);
    cfg_write(CFG_UNUSED_IDX, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    key_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [KEY_LEN_W-1:0]  phase_len [NUM_PHASES];
    logic [CFG_DATA_W-1:0] lo, hi;
    phase_len = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd7, 5'd2, 5'd12};
    rst_ni          = 1'b0;
    send_gap_pct    = 0;
    stall_pct       = 0;
    key_settings    = 0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_DATA;
    in_ch.data_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_KEY_LOW;
    cfg_ch.data     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: data on the reset identity table, then the reset key.
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);
    send_restart();
    send_data(8'h01);
    send_data(8'h80);
    wait_results();
    // zero length behaves as one
    set_key({CFG_DATA_W{1'b1}}, '0, 5'd0);
    send_restart();
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hA5);
    wait_results();
    // length above the maximum saturates
    set_key(rand_word(), {CFG_DATA_W{1'b1}}, 5'd31);
    send_restart();
    send_data(8'h3C);
    send_data(8'hC3);
    send_data(8'h7F);
    wait_results();
    // new key is not used until the next restart
    set_key(64'h0706050403020100, 64'h0F0E0D0C0B0A0908, 5'd17);
    send_data(8'h11);
    send_data(8'hEE);
    send_restart();
    send_data(8'h00);
    send_data(8'hFF);
    wait_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;              stall_pct = 0;              end
        1: begin send_gap_pct = IDLE_HEAVY_PCT; stall_pct = 0;              end
        2: begin send_gap_pct = 0;              stall_pct = IDLE_HEAVY_PCT; end
        default: begin send_gap_pct = IDLE_BOTH_PCT; stall_pct = IDLE_BOTH_PCT; end
      endcase
      lo = (p == 0) ? {CFG_DATA_W{1'b1}} : (p == 1) ? '0 : rand_word();
      hi = (p == 1) ? {CFG_DATA_W{1'b1}} : (p == 0) ? '0 : rand_word();
      set_key(lo, hi, phase_len[p]);
      send_restart();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          // hold off until the output side has caught up
          wait_results();
          if ($urandom_range(1) == 1)
            set_key(rand_word(), rand_word(), KEY_LEN_W'($urandom_range(31)));
        end
        if ($urandom_range(99) < RESTART_PCT) send_restart();
        else send_data(BYTE_W'($urandom_range(255)));
      end
      wait_results();
    end

    repeat (RESTART_SETTLE) @(posedge clk_i);
    $display("Checked %0d output bytes across %0d restarts and %0d key settings.",
             shadow.bytes_checked, shadow.restarts_seen, key_settings);
    $display("Idle modes: none, sender gaps, receiver stalls, both.");
    if (shadow.mismatches == 0 && shadow.expected_out.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
